>>> rtl/pairwise_squared_distances_macros.svh
// ----------------------------------------------------------------------------
// Pairwise squared distances: assertion macros
// Checks that are compiled in for simulation and left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_SQUARED_DISTANCES_MACROS_SVH
`define PAIRWISE_SQUARED_DISTANCES_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent and consequent in the same cycle.
`define PSD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PSD_ASSERT_NOW(label, clk, rst, ante, cons)
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise squared distances: package
// Shared widths, register indexes, reset values and interface structs.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_VECTORS_DEF = 11;
  localparam int MAX_DIMS_DEF    = 16;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int DIST_WIDTH      = 36;
  localparam int INDEX_WIDTH     = 4;
  localparam int VCOUNT_WIDTH    = 4;
  localparam int DCOUNT_WIDTH    = 5;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 5;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VECTOR_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIMENSION_COUNT = 2'd1;

  localparam logic [VCOUNT_WIDTH-1:0] VCOUNT_RESET = 4'd8;
  localparam logic [DCOUNT_WIDTH-1:0] DCOUNT_RESET = 5'd16;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic first;
    logic last;
    logic load_out;
    logic pair_last;
  } psd_cmd_t;

  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } psd_status_t;

endpackage

>>> rtl/psd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module psd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 176
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// Pairwise squared distances: controller
// Holds the configuration, counts the load and walks pairs and dimensions.
// ----------------------------------------------------------------------------
module psd_ctrl #(
  parameter int MAX_VECTORS = psd_pkg::MAX_VECTORS_DEF,
  parameter int MAX_DIMS    = psd_pkg::MAX_DIMS_DEF,
  localparam int VW = $clog2(MAX_VECTORS),
  localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [psd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [psd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  psd_pkg::psd_status_t                 status,
  output psd_pkg::psd_cmd_t                    cmd,
  output logic [VW+KW-1:0]                     wr_addr,
  output logic [VW+KW-1:0]                     rd_addr_a,
  output logic [VW+KW-1:0]                     rd_addr_b,
  output logic [VW-1:0]                        idx_a,
  output logic [VW-1:0]                        idx_b
);

  localparam int DW = (KW + 1 > psd_pkg::DCOUNT_WIDTH) ? KW + 1 : psd_pkg::DCOUNT_WIDTH;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic [psd_pkg::VCOUNT_WIDTH-1:0] vector_count, vector_count_next;
  logic [psd_pkg::DCOUNT_WIDTH-1:0] dimension_count, dimension_count_next;
  logic [VW-1:0] v, v_next;
  logic [VW-1:0] i, i_next;
  logic [VW-1:0] j, j_next;
  logic [KW-1:0] k, k_next;

  logic [psd_pkg::VCOUNT_WIDTH-1:0] n_eff;
  logic [DW-1:0] d_ext, d_eff;
  logic [VW-1:0] v_last;
  logic [KW-1:0] k_last;
  logic          accept, cfg_hit, pair_last;

  always_comb begin
    if (vector_count < psd_pkg::VCOUNT_WIDTH'(2)) begin
      n_eff = psd_pkg::VCOUNT_WIDTH'(2);
    end else if (vector_count > psd_pkg::VCOUNT_WIDTH'(MAX_VECTORS)) begin
      n_eff = psd_pkg::VCOUNT_WIDTH'(MAX_VECTORS);
    end else begin
      n_eff = vector_count;
    end
    d_ext = DW'(dimension_count);
    if (d_ext == '0) begin
      d_eff = DW'(1);
    end else if (d_ext > DW'(MAX_DIMS)) begin
      d_eff = DW'(MAX_DIMS);
    end else begin
      d_eff = d_ext;
    end
  end

  assign v_last    = VW'(n_eff - psd_pkg::VCOUNT_WIDTH'(1));
  assign k_last    = KW'(d_eff - DW'(1));
  assign accept    = (state == ST_LOAD) && in_valid;
  assign cfg_hit   = cfg_write && ((cfg_index == psd_pkg::REG_VECTOR_COUNT) ||
                                   (cfg_index == psd_pkg::REG_DIMENSION_COUNT));
  assign pair_last = (i == v_last - VW'(1)) && (j == v_last);

  assign in_stall      = (state != ST_LOAD);
  assign wr_addr       = {v, k};
  assign rd_addr_a     = {i, k};
  assign rd_addr_b     = {j, k};
  assign idx_a         = i;
  assign idx_b         = j;
  assign cmd.wr_en     = accept;
  assign cmd.rd_en     = (state == ST_ISSUE);
  assign cmd.first     = (k == '0);
  assign cmd.last      = (k == k_last);
  assign cmd.load_out  = (state == ST_FLUSH) && status.sum_ready && status.out_free;
  assign cmd.pair_last = pair_last;

  always_comb begin
    state_next           = state;
    vector_count_next    = vector_count;
    dimension_count_next = dimension_count;
    v_next               = v;
    i_next               = i;
    j_next               = j;
    k_next               = k;
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          if (k == k_last) begin
            k_next = '0;
            if (v == v_last) begin
              v_next     = '0;
              i_next     = '0;
              j_next     = VW'(1);
              state_next = ST_ISSUE;
            end else begin
              v_next = v + VW'(1);
            end
          end else begin
            k_next = k + KW'(1);
          end
        end
      end
      ST_ISSUE: begin
        if (k == k_last) begin
          k_next     = '0;
          state_next = ST_FLUSH;
        end else begin
          k_next = k + KW'(1);
        end
      end
      ST_FLUSH: begin
        if (cmd.load_out) begin
          if (pair_last) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_ISSUE;
            if (j == v_last) begin
              i_next = i + VW'(1);
              j_next = i + VW'(2);
            end else begin
              j_next = j + VW'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
    if (cfg_hit) begin
      v_next = '0;
      k_next = '0;
      if (cfg_index == psd_pkg::REG_VECTOR_COUNT) begin
        vector_count_next = psd_pkg::VCOUNT_WIDTH'(cfg_data);
      end else begin
        dimension_count_next = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      vector_count    <= psd_pkg::VCOUNT_RESET;
      dimension_count <= psd_pkg::DCOUNT_RESET;
      v               <= '0;
      i               <= '0;
      j               <= '0;
      k               <= '0;
    end else begin
      state           <= state_next;
      vector_count    <= vector_count_next;
      dimension_count <= dimension_count_next;
      v               <= v_next;
      i               <= i_next;
      j               <= j_next;
      k               <= k_next;
    end
  end

endmodule

>>> rtl/psd_datapath.sv
// ----------------------------------------------------------------------------
// Pairwise squared distances: datapath
// Vector store, difference, square and accumulate pipeline, output register.
// ----------------------------------------------------------------------------
module psd_datapath #(
  parameter int MAX_VECTORS = psd_pkg::MAX_VECTORS_DEF,
  parameter int MAX_DIMS    = psd_pkg::MAX_DIMS_DEF,
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  localparam int VW = $clog2(MAX_VECTORS),
  localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  psd_pkg::psd_cmd_t                  cmd,
  input  logic [VW+KW-1:0]                   wr_addr,
  input  logic [VW+KW-1:0]                   rd_addr_a,
  input  logic [VW+KW-1:0]                   rd_addr_b,
  input  logic [VW-1:0]                      idx_a,
  input  logic [VW-1:0]                      idx_b,
  input  logic [COORD_WIDTH-1:0]             coordinate,
  output psd_pkg::psd_status_t               status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [psd_pkg::DIST_WIDTH-1:0]     squared_distance,
  output logic [psd_pkg::INDEX_WIDTH-1:0]    first_index,
  output logic [psd_pkg::INDEX_WIDTH-1:0]    second_index,
  output logic                               last_pair
);

  localparam int DEPTH = MAX_VECTORS << KW;

  logic [COORD_WIDTH-1:0]          rdata_a, rdata_b;
  logic                            v1, f1, l1, v2, f2, l2, v3, f3, l3;
  logic signed [COORD_WIDTH:0]     diff;
  logic signed [2*COORD_WIDTH+1:0] prod;
  logic [2*COORD_WIDTH+1:0]        sq;
  logic [psd_pkg::DIST_WIDTH-1:0]  acc;
  logic                            sum_ready;

  psd_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (wr_addr),
    .wdata   (coordinate),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    diff <= $signed({rdata_a[COORD_WIDTH-1], rdata_a}) -
            $signed({rdata_b[COORD_WIDTH-1], rdata_b});
    sq   <= $unsigned(prod);
    if (v3) begin
      if (f3) begin
        acc <= psd_pkg::DIST_WIDTH'(sq);
      end else begin
        acc <= acc + psd_pkg::DIST_WIDTH'(sq);
      end
    end
    if (cmd.load_out) begin
      squared_distance <= acc;
      first_index      <= psd_pkg::INDEX_WIDTH'(idx_a);
      second_index     <= psd_pkg::INDEX_WIDTH'(idx_b);
      last_pair        <= cmd.pair_last;
    end
    f1 <= cmd.first;
    l1 <= cmd.last;
    f2 <= f1;
    l2 <= l1;
    f3 <= f2;
    l3 <= l2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      sum_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      if (cmd.load_out) begin
        sum_ready <= 1'b0;
      end else if (v3 && l3) begin
        sum_ready <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.sum_ready = sum_ready;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

>>> rtl/pairwise_squared_distances.sv
// ----------------------------------------------------------------------------
// Pairwise squared distances
// Loads a set of vectors and emits the squared distance of every pair.
// ----------------------------------------------------------------------------
// Coordinates arrive on the input channel (in_valid, in_stall, coordinate),
// vector 0 first, one item per cycle while in_stall is low, n vectors of d
// coordinates each, as set by the vector_count and dimension_count registers
// on the write port. After the last coordinate the block stalls its input
// and walks the pairs i < j in order, with one multiply-accumulate over the
// dimensions. For each pair the block issues d store reads, then the difference,
// square and accumulate pipeline drains before the sum moves to the output
// register. A run of n vectors loads n*d coordinates and yields n(n-1)/2
// results; last_pair marks the final result of the run.
// A stall on the output channel holds the result in place and pauses the
// pair walk; loading of the next set starts while the final result waits.
// Reset clears the load, sets vector_count to 8 and dimension_count to 16,
// and leaves the vector store undefined until written.
// A register write discards a partial load.
// ----------------------------------------------------------------------------
`include "pairwise_squared_distances_macros.svh"

module pairwise_squared_distances #(
  parameter int MAX_VECTORS = psd_pkg::MAX_VECTORS_DEF,
  parameter int MAX_DIMS    = psd_pkg::MAX_DIMS_DEF,
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [psd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [psd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_WIDTH-1:0]              coordinate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psd_pkg::DIST_WIDTH-1:0]      squared_distance,
  output logic [psd_pkg::INDEX_WIDTH-1:0]     first_index,
  output logic [psd_pkg::INDEX_WIDTH-1:0]     second_index,
  output logic                                last_pair
);

  localparam int VW = $clog2(MAX_VECTORS);
  localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  psd_pkg::psd_cmd_t    cmd;
  psd_pkg::psd_status_t status;
  logic [VW+KW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [VW-1:0]        idx_a, idx_b;

  psd_ctrl #(
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .idx_a     (idx_a),
    .idx_b     (idx_b)
  );

  psd_datapath #(
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .wr_addr          (wr_addr),
    .rd_addr_a        (rd_addr_a),
    .rd_addr_b        (rd_addr_b),
    .idx_a            (idx_a),
    .idx_b            (idx_b),
    .coordinate       (coordinate),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .squared_distance (squared_distance),
    .first_index      (first_index),
    .second_index     (second_index),
    .last_pair        (last_pair)
  );

  `PSD_ASSERT_NOW(a_pair_order, clk, rst, out_valid, first_index < second_index)
  `PSD_ASSERT_NOW(a_last_pair_adjacent, clk, rst, out_valid && last_pair, second_index == first_index + psd_pkg::INDEX_WIDTH'(1))
  `PSD_ASSERT_NOW(a_no_load_while_summing, clk, rst, status.sum_ready, in_stall)
  `PSD_ASSERT_NEXT(a_load_fills_output, clk, rst, cmd.load_out, out_valid)

endmodule
